### hdl/lmrs_pkg.sv
// shared types and constants for the led matrix row scan driver
// no dependencies; imported by the sequencer and the top level
package lmrs_pkg;

   // input word opcodes
   typedef enum logic [2:0] {
      OP_TICK          = 3'd0,
      OP_START_REFRESH = 3'd1,
      OP_SET_PIXEL     = 3'd2,
      OP_WRITE_ROW     = 3'd3,
      OP_ALL_ON        = 3'd4,
      OP_ALL_OFF       = 3'd5,
      OP_START_CLEAR   = 3'd6,
      OP_NOP           = 3'd7
   } lmrs_op_type;

   // dwell length after reset
   localparam logic [15:0] DWELL_RESET = 16'd200;

   // sequencer commands for one word
   typedef struct packed {
      logic tick;
      logic start_refresh;
      logic start_clear;
   } lmrs_cmd_type;

   // shift register pins and busy flag
   typedef struct packed {
      logic busy;
      logic latch;
      logic clock;
      logic data;
   } lmrs_pins_type;

endpackage

### hdl/lmrs_seq.sv
// refresh and clear pin sequencer, one pin event per tick
// depends on lmrs_pkg for the command and pin structs
module lmrs_seq #(
   parameter int ROWS    = 8,
   parameter int COLUMNS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  lmrs_pkg::lmrs_cmd_type        cmd,
   input  logic [COLUMNS-1:0]            row_word,
   input  logic [15:0]                   dwell_ticks,
   output logic [$clog2(ROWS)-1:0]       scan_row,
   output lmrs_pkg::lmrs_pins_type       pins,
   output logic [ROWS-1:0]               row_lines
);
   import lmrs_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int BW = $clog2(COLUMNS);

   typedef enum logic [3:0] {
      PH_IDLE, PH_R_LAT_LO, PH_R_DATA, PH_R_CLK_HI, PH_R_CLK_LO, PH_R_LAT_HI,
      PH_R_ROW_ON, PH_R_DWELL, PH_R_ROW_OFF, PH_C_DATA, PH_C_CLK_HI,
      PH_C_CLK_LO, PH_C_LAT_HI, PH_C_LAT_LO
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [BW-1:0]     bit_ff, bit_in;
   logic [15:0]       dwell_ff, dwell_in;
   logic              data_ff, data_in;
   logic              clk_ff, clk_in;
   logic              latch_ff, latch_in;
   logic [ROWS-1:0]   rows_ff, rows_in;
   logic              idle;
   logic              last_bit;
   logic              last_row;
   logic [15:0]       dwell_dec;

   assign idle     = (phase_ff == PH_IDLE);
   assign last_bit = (bit_ff == BW'(COLUMNS - 1));
   assign last_row = (row_ff == RW'(ROWS - 1));
   assign dwell_dec = (dwell_ff != 16'd0) ? dwell_ff - 16'd1 : dwell_ff;

   // next pin event
   always_comb begin
      phase_in = phase_ff;
      row_in   = row_ff;
      bit_in   = bit_ff;
      dwell_in = dwell_ff;
      data_in  = data_ff;
      clk_in   = clk_ff;
      latch_in = latch_ff;
      rows_in  = rows_ff;
      if (idle) begin
         if (cmd.start_refresh) begin
            row_in   = '0;
            bit_in   = '0;
            phase_in = PH_R_LAT_LO;
         end else if (cmd.start_clear) begin
            bit_in   = '0;
            phase_in = PH_C_DATA;
         end
      end else if (cmd.tick) begin
         unique case (phase_ff)
            PH_R_LAT_LO: begin
               latch_in = 1'b0;
               bit_in   = '0;
               phase_in = PH_R_DATA;
            end
            PH_R_DATA: begin
               data_in  = row_word[BW'(COLUMNS - 1) - bit_ff];
               phase_in = PH_R_CLK_HI;
            end
            PH_R_CLK_HI: begin
               clk_in   = 1'b1;
               phase_in = PH_R_CLK_LO;
            end
            PH_R_CLK_LO: begin
               clk_in   = 1'b0;
               bit_in   = last_bit ? '0 : bit_ff + BW'(1);
               phase_in = last_bit ? PH_R_LAT_HI : PH_R_DATA;
            end
            PH_R_LAT_HI: begin
               latch_in = 1'b1;
               phase_in = PH_R_ROW_ON;
            end
            PH_R_ROW_ON: begin
               rows_in[row_ff] = 1'b0;
               dwell_in        = dwell_ticks;
               phase_in        = PH_R_DWELL;
            end
            PH_R_DWELL: begin
               dwell_in = dwell_dec;
               if (dwell_dec == 16'd0) begin
                  phase_in = PH_R_ROW_OFF;
               end
            end
            PH_R_ROW_OFF: begin
               rows_in[row_ff] = 1'b1;
               row_in          = last_row ? '0 : row_ff + RW'(1);
               phase_in        = last_row ? PH_IDLE : PH_R_LAT_LO;
            end
            PH_C_DATA: begin
               data_in  = 1'b0;
               bit_in   = '0;
               phase_in = PH_C_CLK_HI;
            end
            PH_C_CLK_HI: begin
               clk_in   = 1'b1;
               phase_in = PH_C_CLK_LO;
            end
            PH_C_CLK_LO: begin
               clk_in   = 1'b0;
               phase_in = PH_C_LAT_HI;
            end
            PH_C_LAT_HI: begin
               latch_in = 1'b1;
               phase_in = PH_C_LAT_LO;
            end
            PH_C_LAT_LO: begin
               latch_in = 1'b0;
               bit_in   = last_bit ? '0 : bit_ff + BW'(1);
               phase_in = last_bit ? PH_IDLE : PH_C_CLK_HI;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // state and pin registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         row_ff   <= '0;
         bit_ff   <= '0;
         dwell_ff <= '0;
         data_ff  <= 1'b0;
         clk_ff   <= 1'b0;
         latch_ff <= 1'b0;
         rows_ff  <= '1;
      end else if (step) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         bit_ff   <= bit_in;
         dwell_ff <= dwell_in;
         data_ff  <= data_in;
         clk_ff   <= clk_in;
         latch_ff <= latch_in;
         rows_ff  <= rows_in;
      end
   end

   assign scan_row   = row_ff;
   assign pins.busy  = ~idle;
   assign pins.latch = latch_ff;
   assign pins.clock = clk_ff;
   assign pins.data  = data_ff;
   assign row_lines  = rows_ff;

endmodule

### hdl/led_matrix_row_scan_driver.sv
// Row-multiplexed LED matrix driver: a ROWS x COLUMNS frame buffer feeding a serial
// column shift register. Each input word either edits the buffer or starts/advances
// a pin sequence, and produces exactly one response word with the pin levels after
// that word. One word is taken per clock while the response is not stalled; a word
// is held in the input register, then moves on into the response registers.
// The response is the sequencer's pin registers themselves, held until taken; a
// stalled response holds the word in the input register, and a full input register
// accepts no further word. Depends on lmrs_pkg and lmrs_seq.
module led_matrix_row_scan_driver #(
   parameter int ROWS    = 8,
   parameter int COLUMNS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] column, [5:3] row_index, [6] pixel_value, [14:7] row_bits, [15] zero
   input  logic [15:0] req_tdata,
   // [2:0] opcode
   input  logic [2:0]  req_tuser,
   // response words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] serial_data, [1] shift_clock, [2] latch, [10:3] row_drive, [11] busy_res,
   // [15:12] zero
   output logic [15:0] rsp_tdata,
   // dwell register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import lmrs_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int BW = $clog2(COLUMNS);

   logic                 in_valid_ff;
   lmrs_op_type          in_op_ff;
   logic [14:0]          in_data_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          dwell_ff;
   logic [COLUMNS-1:0]   fb_ff [ROWS];
   logic [COLUMNS-1:0]   fb_in [ROWS];
   logic                 go;
   logic [2:0]           column;
   logic [2:0]           row_idx;
   logic                 pixel;
   logic [7:0]           row_bits;
   logic                 row_ok;
   logic [RW-1:0]        row_sel;
   logic [BW-1:0]        pix_bit;
   lmrs_cmd_type         cmd;
   logic [RW-1:0]        scan_row;
   lmrs_pins_type        pins;
   logic [ROWS-1:0]      row_lines;
   logic [ROWS+7:0]      row_pad;

   // word moves on when the response slot is free or being emptied
   assign go         = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | go;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_op_ff    <= OP_NOP;
         in_data_ff  <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (req_tvalid && req_tready) begin
            in_op_ff   <= lmrs_op_type'(req_tuser);
            in_data_ff <= req_tdata[14:0];
         end
      end
   end

   assign column   = in_data_ff[2:0];
   assign row_idx  = in_data_ff[5:3];
   assign pixel    = in_data_ff[6];
   assign row_bits = in_data_ff[14:7];
   assign row_ok   = (int'(row_idx) < ROWS);
   assign row_sel  = RW'(row_idx);
   assign pix_bit  = BW'(COLUMNS - 1) - BW'(column);

   // sequencer commands
   always_comb begin
      cmd.tick          = (in_op_ff == OP_TICK);
      cmd.start_refresh = (in_op_ff == OP_START_REFRESH);
      cmd.start_clear   = (in_op_ff == OP_START_CLEAR);
   end

   // frame buffer edits
   always_comb begin
      fb_in = fb_ff;
      unique case (in_op_ff)
         OP_SET_PIXEL: begin
            if (row_ok) begin
               fb_in[row_sel][pix_bit] = pixel;
            end
         end
         OP_WRITE_ROW: begin
            if (row_ok) begin
               fb_in[row_sel] = COLUMNS'(row_bits);
            end
         end
         OP_ALL_ON: begin
            for (int i = 0; i < ROWS; i++) begin
               fb_in[i] = '1;
            end
         end
         OP_ALL_OFF: begin
            for (int i = 0; i < ROWS; i++) begin
               fb_in[i] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // frame buffer, dwell register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            fb_ff[i] <= '0;
         end
         dwell_ff     <= DWELL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            fb_ff <= fb_in;
         end
         if (csr_wr_en) begin
            dwell_ff <= csr_wr_data;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   lmrs_seq #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (go),
      .cmd         (cmd),
      .row_word    (fb_ff[scan_row]),
      .dwell_ticks (dwell_ff),
      .scan_row    (scan_row),
      .pins        (pins),
      .row_lines   (row_lines)
   );

   // response word, rows beyond eight not shown
   assign row_pad    = (ROWS + 8)'(row_lines);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, pins.busy, row_pad[7:0], pins.latch, pins.clock,
                        pins.data};

endmodule

### hdl/lmrs_check.sv
// port-level checks for the led matrix row scan driver
// no package needed; bound to led_matrix_row_scan_driver below
module lmrs_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // at most one row powered at a time
   a_one_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(~rsp_tdata[10:3]))
      else $error("more than one row powered");

   // idle sequencer leaves the shift clock low
   a_idle_clk: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[11] |-> !rsp_tdata[1])
      else $error("shift clock high while idle");

   // idle sequencer leaves every row released
   a_idle_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[11] |-> (rsp_tdata[10:3] == 8'hFF))
      else $error("row powered while idle");

endmodule

bind led_matrix_row_scan_driver lmrs_check u_lmrs_check (.*);
